// ----- sv/sdrr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sdrr_pkg;

    localparam int BUFFER_DEPTH = 4096;
    localparam int IDX_W        = $clog2(BUFFER_DEPTH);
    localparam int FRAC_W       = 8;
    localparam int PH_W         = IDX_W + FRAC_W;
    localparam int SAMPLE_W     = 16;
    localparam int RATE_W       = 18;
    localparam int INC_W        = 11;
    localparam int OP_W         = 3;
    localparam int OFFSET_W     = 16;

    localparam int BASE_RATE    = 44100;

    localparam logic [INC_W-1:0] RESET_INC = INC_W'(256);

    localparam logic [OP_W-1:0] OP_WORD_WRITE = 3'd0;
    localparam logic [OP_W-1:0] OP_BYTE_WRITE = 3'd1;
    localparam logic [OP_W-1:0] OP_WORD_READ  = 3'd2;
    localparam logic [OP_W-1:0] OP_BYTE_READ  = 3'd3;
    localparam logic [OP_W-1:0] OP_PLAY       = 3'd4;

    localparam logic [OFFSET_W-1:0] LEFT_OFFSET  = 16'd2;
    localparam logic [OFFSET_W-1:0] RIGHT_OFFSET = 16'd6;

    localparam logic [SAMPLE_W-1:0] WORD_READ_VAL = 16'hFFFF;
    localparam logic [SAMPLE_W-1:0] BYTE_READ_VAL = 16'h00FF;

    typedef enum logic [1:0] {
        RES_WORD,
        RES_BYTE,
        RES_PLAY
    } t_res;

endpackage

`default_nettype wire

// ----- sv/sdrr_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sdrr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/sdrr_inc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sdrr_inc_div
    import sdrr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [RATE_W-1:0] i_rate,
    output logic                   o_busy,
    output logic      [INC_W-1:0]  o_increment
);

    // ceil(2^42 / 44100); the product error stays below one lsb for any 18-bit rate
    localparam int RECIP_W     = 27;
    localparam int PROD_W      = RATE_W + RECIP_W;
    localparam int RECIP_SHIFT = 42 - FRAC_W;
    localparam logic [RECIP_W-1:0] RECIP = 27'd99728946;

    logic [RATE_W-1:0] r_rate;
    logic              r_busy;
    logic [INC_W-1:0]  r_inc;
    logic [PROD_W-1:0] product;

    // floor(rate * 256 / 44100) by multiply with the scaled reciprocal
    assign product = PROD_W'(r_rate) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_inc  <= RESET_INC;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_rate <= i_rate;
        end else if (r_busy) begin
            r_busy <= 1'b0;
            r_inc  <= product[RECIP_SHIFT +: INC_W];
        end
    end

    assign o_busy      = r_busy;
    assign o_increment = r_inc;

endmodule

`default_nettype wire

// ----- sv/stereo_dac_ring_resampler_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Stereo DAC ring buffer with phase-accumulator playback.
// Input channel (i_valid / o_stall): one bus or playback item per transfer.
// Word writes to offset 2 or 6 store a sample into the left or right ring
// and advance that ring's write pointer; they give no result. Word and byte
// reads answer constants; a playback item returns the sample at the integer
// part of the channel's 12.8 phase and advances the phase.
// Output channel (o_valid / i_stall): one result per read or playback item,
// registered through the memory read stage and the output register; one
// item per cycle sustained while neither i_stall nor a rate update holds it.
// A result held by i_stall parks in the output register; one more item is
// taken into the memory read stage, after which o_stall rises.
// Config channel (i_cfg_valid / o_cfg_ready): a rate write registers the rate
// and sets the divider busy, then forms the phase increment by reciprocal
// multiply; input and config are stalled while the divider is busy.
// Reset: pointers and phases go to zero, the increment to 256. Entries not
// yet written read as zero, tracked by write pointer and a wrap flag, so no
// clearing pass is needed.

module stereo_dac_ring_resampler_core
    import sdrr_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [OP_W-1:0]     i_operation,
    input  wire logic [OFFSET_W-1:0] i_reg_offset,
    input  wire logic [SAMPLE_W-1:0] i_write_data,
    input  wire logic                i_play_channel,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic      [SAMPLE_W-1:0] o_read_data,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [RATE_W-1:0]   i_cfg_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFER_DEPTH - 1);

    logic [IDX_W-1:0]    r_lwp;
    logic [IDX_W-1:0]    r_rwp;
    logic                r_lwrap;
    logic                r_rwrap;
    logic [PH_W-1:0]     r_lph;
    logic [PH_W-1:0]     r_rph;

    logic                r_s1_valid;
    t_res                r_s1_kind;
    logic                r_s1_chan;
    logic                r_s1_written;

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_data;
    logic [SAMPLE_W-1:0] n_out_data;

    logic                div_busy;
    logic [INC_W-1:0]    increment;
    logic                cfg_fire;

    logic                fire;
    logic                s1_move;
    logic                we_l;
    logic                we_r;
    logic                re_l;
    logic                re_r;
    logic                has_result;
    t_res                n_kind;
    logic [IDX_W-1:0]    raddr_l;
    logic [IDX_W-1:0]    raddr_r;
    logic                written_l;
    logic                written_r;
    logic [SAMPLE_W-1:0] rd_l;
    logic [SAMPLE_W-1:0] rd_r;
    logic [SAMPLE_W-1:0] rd_sel;

    assign s1_move  = !r_out_valid || !i_stall;
    assign o_stall  = (r_s1_valid && !s1_move) || div_busy;
    assign fire     = i_valid && !o_stall;
    assign o_cfg_ready = !div_busy;
    assign cfg_fire = i_cfg_valid && o_cfg_ready;

    assign we_l = fire && (i_operation == OP_WORD_WRITE) && (i_reg_offset == LEFT_OFFSET);
    assign we_r = fire && (i_operation == OP_WORD_WRITE) && (i_reg_offset == RIGHT_OFFSET);
    assign re_l = fire && (i_operation == OP_PLAY) && !i_play_channel;
    assign re_r = fire && (i_operation == OP_PLAY) && i_play_channel;

    assign raddr_l = r_lph[PH_W-1:FRAC_W];
    assign raddr_r = r_rph[PH_W-1:FRAC_W];

    // an entry below the write pointer, or any entry once wrapped, holds data
    assign written_l = r_lwrap || (raddr_l < r_lwp);
    assign written_r = r_rwrap || (raddr_r < r_rwp);

    always_comb begin
        has_result = 1'b1;
        n_kind     = RES_PLAY;
        unique case (i_operation)
            OP_WORD_READ: n_kind = RES_WORD;
            OP_BYTE_READ: n_kind = RES_BYTE;
            OP_PLAY:      n_kind = RES_PLAY;
            default:      has_result = 1'b0;
        endcase
    end

    sdrr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (we_l),
        .i_waddr (r_lwp),
        .i_wdata (i_write_data),
        .i_re    (re_l),
        .i_raddr (raddr_l),
        .o_rdata (rd_l)
    );

    sdrr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (we_r),
        .i_waddr (r_rwp),
        .i_wdata (i_write_data),
        .i_re    (re_r),
        .i_raddr (raddr_r),
        .o_rdata (rd_r)
    );

    sdrr_inc_div u_inc_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (cfg_fire),
        .i_rate      (i_cfg_data),
        .o_busy      (div_busy),
        .o_increment (increment)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lwp   <= '0;
            r_rwp   <= '0;
            r_lwrap <= 1'b0;
            r_rwrap <= 1'b0;
            r_lph   <= '0;
            r_rph   <= '0;
        end else begin
            if (we_l) begin
                r_lwp <= r_lwp + IDX_W'(1);
                if (r_lwp == LAST_IDX) begin
                    r_lwrap <= 1'b1;
                end
            end
            if (we_r) begin
                r_rwp <= r_rwp + IDX_W'(1);
                if (r_rwp == LAST_IDX) begin
                    r_rwrap <= 1'b1;
                end
            end
            if (re_l) begin
                r_lph <= r_lph + PH_W'(increment);
            end
            if (re_r) begin
                r_rph <= r_rph + PH_W'(increment);
            end
        end
    end

    // memory read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (fire && has_result) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
        if (fire && has_result) begin
            r_s1_kind    <= n_kind;
            r_s1_chan    <= i_play_channel;
            r_s1_written <= i_play_channel ? written_r : written_l;
        end
    end

    assign rd_sel = r_s1_chan ? rd_r : rd_l;

    always_comb begin
        unique case (r_s1_kind)
            RES_WORD: n_out_data = WORD_READ_VAL;
            RES_BYTE: n_out_data = BYTE_READ_VAL;
            RES_PLAY: n_out_data = r_s1_written ? rd_sel : '0;
            default:  n_out_data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s1_valid && s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (r_s1_valid && s1_move) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;

`ifndef SYNTHESIS
    a_cfg_starts_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_fire |=> div_busy)
        else $error("rate write did not start the increment divide");

    a_stage_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_move) |=> r_out_valid)
        else $error("read stage moved but output register is empty");

    a_left_ptr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we_l |=> (r_lwp == $past(r_lwp) + IDX_W'(1)))
        else $error("left write pointer did not advance by one");

    a_wrap_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lwrap || r_rwrap) |=> ((r_lwrap || !$past(r_lwrap)) && (r_rwrap || !$past(r_rwrap))))
        else $error("ring wrap flag cleared without reset");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_stereo_dac_ring_resampler_core.sv -----
`timescale 1ns / 1ps

module tb_stereo_dac_ring_resampler_core;
    import sdrr_pkg::*;

    // operation codes the block ignores
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam int RESULTS_PER_PHASE = 92;

    class dac_scoreboard;
        bit   [SAMPLE_W-1:0] left_ring [BUFFER_DEPTH];
        bit   [SAMPLE_W-1:0] right_ring[BUFFER_DEPTH];
        logic [IDX_W-1:0]    left_wr;
        logic [IDX_W-1:0]    right_wr;
        logic [PH_W-1:0]     left_ph;
        logic [PH_W-1:0]     right_ph;
        logic [INC_W-1:0]    phase_step;
        logic [SAMPLE_W-1:0] sample_q[$];
        int errors;
        int checked;
        int items_in;
        int plays;
        int stores;

        function new();
            foreach (left_ring[k]) begin
                left_ring[k]  = '0;
                right_ring[k] = '0;
            end
            left_wr    = '0;
            right_wr   = '0;
            left_ph    = '0;
            right_ph   = '0;
            phase_step = RESET_INC;
            errors     = 0;
            checked    = 0;
            items_in   = 0;
            plays      = 0;
            stores     = 0;
        endfunction

        function void set_rate(logic [RATE_W-1:0] rate);
            phase_step = INC_W'((int'(rate) << FRAC_W) / BASE_RATE);
        endfunction

        function int pending();
            return sample_q.size();
        endfunction

        function void note_item(logic [OP_W-1:0] op, logic [OFFSET_W-1:0] off,
                                logic [SAMPLE_W-1:0] data, logic chan);
            items_in++;
            case (op)
                OP_WORD_WRITE: begin
                    if (off == LEFT_OFFSET) begin
                        left_ring[left_wr] = data;
                        left_wr = left_wr + 1'b1;
                        stores++;
                    end else if (off == RIGHT_OFFSET) begin
                        right_ring[right_wr] = data;
                        right_wr = right_wr + 1'b1;
                        stores++;
                    end
                end
                OP_WORD_READ: sample_q.push_back(WORD_READ_VAL);
                OP_BYTE_READ: sample_q.push_back(BYTE_READ_VAL);
                OP_PLAY: begin
                    plays++;
                    // integer part of the 12.8 phase picks the entry
                    if (!chan) begin
                        sample_q.push_back(left_ring[left_ph[PH_W-1:FRAC_W]]);
                        left_ph = left_ph + PH_W'(phase_step);
                    end else begin
                        sample_q.push_back(right_ring[right_ph[PH_W-1:FRAC_W]]);
                        right_ph = right_ph + PH_W'(phase_step);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_sample(logic [SAMPLE_W-1:0] actual);
            logic [SAMPLE_W-1:0] want;
            if (sample_q.size() == 0) begin
                $error("read_data: expected none, actual %h", actual);
                errors++;
                return;
            end
            want = sample_q.pop_front();
            checked++;
            if (actual !== want) begin
                $error("read_data: expected %h, actual %h", want, actual);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_valid        = 1'b0;
    logic [OP_W-1:0]     i_operation    = '0;
    logic [OFFSET_W-1:0] i_reg_offset   = '0;
    logic [SAMPLE_W-1:0] i_write_data   = '0;
    logic                i_play_channel = 1'b0;
    logic                i_stall        = 1'b0;
    logic                i_cfg_valid    = 1'b0;
    logic [RATE_W-1:0]   i_cfg_data     = '0;
    logic                o_stall;
    logic                o_valid;
    logic [SAMPLE_W-1:0] o_read_data;
    logic                o_cfg_ready;

    dac_scoreboard sb;
    bit source_idle_en = 1'b1;
    bit sink_idle_en   = 1'b1;
    int stall_left     = 0;
    int rates_written  = 0;

    stereo_dac_ring_resampler_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_reg_offset   (i_reg_offset),
        .i_write_data   (i_write_data),
        .i_play_channel (i_play_channel),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_read_data    (o_read_data),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // results are checked before the input of the same edge is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.check_sample(o_read_data);
            if (i_valid && !o_stall)
                sb.note_item(i_operation, i_reg_offset, i_write_data, i_play_channel);
        end
    end

    // random back-pressure in bursts while sink_idle_en is set
    always @(posedge i_clk) begin
        if (!sink_idle_en) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 4);
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [OFFSET_W-1:0] off,
                             input logic [SAMPLE_W-1:0] data, input logic chan);
        int gap;
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_reg_offset   <= off;
        i_write_data   <= data;
        i_play_channel <= chan;
        do @(posedge i_clk); while (o_stall);
        if (source_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // rate writes only with nothing in flight; word writes give no result,
    // so the task also waits after the scoreboard empties to let the pipeline drain
    task automatic write_rate(input logic [RATE_W-1:0] rate);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= rate;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_rate(rate);
        rates_written++;
    endtask

    task automatic random_item(output bit counts);
        logic [OP_W-1:0]     op;
        logic [OFFSET_W-1:0] off;
        logic [SAMPLE_W-1:0] data;
        logic                chan;
        int                  pick;
        pick   = $urandom_range(0, 99);
        off    = OFFSET_W'($urandom);
        data   = SAMPLE_W'($urandom);
        chan   = 1'($urandom);
        op     = OP_PLAY;
        counts = 1'b1;
        if (pick < 40) begin
            op  = OP_WORD_WRITE;
            off = chan ? RIGHT_OFFSET : LEFT_OFFSET;
        end else if (pick < 75) begin
            op = OP_PLAY;
        end else if (pick < 82) begin
            op = OP_WORD_READ;
        end else if (pick < 88) begin
            op = OP_BYTE_READ;
        end else begin
            // noise: ignored codes, byte writes, stray word-write offsets
            counts = 1'b0;
            case ($urandom_range(0, 2))
                0:       op = OP_BYTE_WRITE;
                1:       op = OP_WORD_WRITE;
                default: op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            endcase
        end
        send_item(op, off, data, chan);
    endtask

    initial begin
        logic [RATE_W-1:0] rate_plan[7];
        int                done;
        bit                counts;
        sb = new();
        rate_plan[0] = '0;
        rate_plan[1] = '1;
        rate_plan[2] = RATE_W'(22050);
        rate_plan[3] = RATE_W'(88200);
        rate_plan[4] = RATE_W'(173);
        rate_plan[5] = RATE_W'($urandom_range(0, (1 << RATE_W) - 1));
        rate_plan[6] = RATE_W'(BASE_RATE);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bus reads answer constants whatever the offset
        send_item(OP_WORD_READ, '1, '1, 1'b1);
        send_item(OP_BYTE_READ, '0, '0, 1'b0);
        send_item(OP_WORD_WRITE, LEFT_OFFSET, 16'hFFFF, 1'b1);
        send_item(OP_WORD_WRITE, LEFT_OFFSET, 16'h0000, 1'b0);
        send_item(OP_WORD_WRITE, LEFT_OFFSET, 16'hA5C3, 1'b0);
        send_item(OP_WORD_WRITE, RIGHT_OFFSET, 16'h8001, 1'b0);
        send_item(OP_WORD_WRITE, RIGHT_OFFSET, 16'h7FFE, 1'b1);
        send_item(OP_WORD_WRITE, LEFT_OFFSET + 1'b1, 16'h1234, 1'b0);
        send_item(OP_WORD_WRITE, '1, 16'h5555, 1'b1);
        send_item(OP_BYTE_WRITE, LEFT_OFFSET, 16'hAAAA, 1'b0);
        send_item(OP_SPARE_LO, RIGHT_OFFSET, '1, 1'b1);
        send_item(OP_SPARE_LO + 1'b1, LEFT_OFFSET, '0, 1'b0);
        send_item(OP_SPARE_HI, '1, '1, 1'b1);
        // playback ignores offset and data; the last reads run past the writes
        send_item(OP_PLAY, '1, '1, 1'b0);
        send_item(OP_PLAY, '0, '0, 1'b0);
        send_item(OP_PLAY, RIGHT_OFFSET, 16'h1111, 1'b0);
        send_item(OP_PLAY, LEFT_OFFSET, 16'h2222, 1'b0);
        send_item(OP_PLAY, '1, '0, 1'b1);
        send_item(OP_PLAY, '0, '1, 1'b1);
        send_item(OP_PLAY, '1, '1, 1'b1);

        foreach (rate_plan[p]) begin
            write_rate(rate_plan[p]);
            if (p == 6) begin
                source_idle_en = 1'b0;
                sink_idle_en   = 1'b0;
            end
            done = 0;
            while (done < RESULTS_PER_PHASE) begin
                random_item(counts);
                done += counts;
            end
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d input transfers, %0d results checked, %0d playback reads",
                 sb.items_in, sb.checked, sb.plays);
        $display("%0d samples stored, %0d rate settings including zero and full scale",
                 sb.stores, rates_written);
        if (sb.errors == 0) begin
            $display("PASS stereo_dac_ring_resampler_core");
        end else begin
            $display("FAIL stereo_dac_ring_resampler_core");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAIL stereo_dac_ring_resampler_core");
        $finish;
    end

endmodule
